>>> design/skf_pkg.sv
// Shared constants and types for the scalar Kalman filter.
// No dependencies; imported by skf_serial_mul and scalar_kalman_filter.
`timescale 1ns / 1ps
`default_nettype none

package skf_pkg;

  localparam int W          = 32;              // data word width
  localparam int FRAC_BITS  = 16;              // fraction bits of the fixed-point format
  localparam int DIV_W      = W + FRAC_BITS;   // dividend width of the gain division
  localparam int MUL_CNT_W  = $clog2(W);
  localparam int DIV_CNT_W  = $clog2(DIV_W);
  localparam int CFG_IDX_W  = 3;
  localparam int NARROW_W   = 31;              // width of R and P0 registers

  localparam logic [CFG_IDX_W-1:0] REG_TRANSITION = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OBSERVE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NOISE      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_EST   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_COV   = 3'd4;

  localparam logic signed [W-1:0] ONE_FX = W'(1 << FRAC_BITS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LAUNCH,
    ST_MUL,
    ST_DIV,
    ST_DIVFIN,
    ST_DONE
  } state_t;

  // product sequence of one measurement
  typedef enum logic [3:0] {
    OP_FX = 4'd0,   // x  = F*est
    OP_FP = 4'd1,   // t  = F*cov
    OP_TF = 4'd2,   // p  = t*F
    OP_HX = 4'd3,   // y  = z - H*x
    OP_HP = 4'd4,   // t  = H*p
    OP_TH = 4'd5,   // s  = t*H + R
    OP_PH = 4'd6,   // num = p*H, then divide
    OP_KY = 4'd7,   // est = x + k*y
    OP_KH = 4'd8,   // t  = k*H
    OP_TP = 4'd9    // cov = p - t*p
  } step_t;

  typedef struct packed {
    logic start;
    logic signed [W-1:0] a;
    logic signed [W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic signed [W-1:0] res;
  } mul_rsp_t;

endpackage

`default_nettype wire

>>> design/skf_serial_mul.sv
// Bit-serial signed fixed-point multiplier: one multiplier bit per cycle.
// Result is floor(a*b / 2^FRAC_BITS) saturated to W bits. Uses skf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module skf_serial_mul
  import skf_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire mul_req_t req,
  output mul_rsp_t      rsp
);

  logic signed [W:0]      acc_r;
  logic [W-1:0]           lo_r;
  logic signed [W-1:0]    a_r;
  logic [MUL_CNT_W-1:0]   cnt_r;
  logic                   run_r;
  logic                   fin_r;
  logic                   done_r;
  logic signed [W-1:0]    res_r;

  logic                   last;
  logic signed [W:0]      addend;
  logic signed [W:0]      sum;
  logic [2*W-1:0]         prod;
  logic [W-FRAC_BITS:0]   top_bits;
  logic                   in_range;
  logic signed [W-1:0]    sat_val;

  // sign bit of the multiplier carries negative weight
  assign last   = (cnt_r == MUL_CNT_W'(W - 1));
  assign addend = lo_r[0] ? {a_r[W-1], a_r} : '0;
  assign sum    = last ? (acc_r - addend) : (acc_r + addend);

  assign prod     = {acc_r[W-1:0], lo_r};
  assign top_bits = prod[2*W-1:FRAC_BITS+W-1];
  assign in_range = (top_bits == '0) || (top_bits == '1);
  always_comb begin
    if (in_range) begin
      sat_val = prod[FRAC_BITS+W-1:FRAC_BITS];
    end else if (prod[2*W-1]) begin
      sat_val = {1'b1, {(W-1){1'b0}}};
    end else begin
      sat_val = {1'b0, {(W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      // done pulses for one cycle after the saturation cycle
      done_r <= fin_r & ~run_r & ~req.start;
      if (req.start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (last) begin
          run_r <= 1'b0;
          fin_r <= 1'b1;
        end
      end else if (fin_r) begin
        fin_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      a_r   <= req.a;
      lo_r  <= req.b;
      acc_r <= '0;
    end else if (run_r) begin
      acc_r <= sum >>> 1;
      lo_r  <= {sum[0], lo_r[W-1:1]};
    end
    if (fin_r) begin
      res_r <= sat_val;
    end
  end

  assign rsp.busy = run_r | fin_r;
  assign rsp.done = done_r;
  assign rsp.res  = res_r;

endmodule

`default_nettype wire

>>> design/scalar_kalman_filter.sv
// Each accepted measurement word yields one result word: ten products run in turn
//   on the shared bit-serial multiplier (one multiplier bit a cycle), and a restoring
//   division forms the gain unless the innovation variance is zero.
// One measurement at a time: a new word is accepted only after the last result loads.
// Reset (rst_n low, synchronous): registers back to F=H=R=P0=1.0, x0=0;
//   estimate/covariance reload; no result pending.
`timescale 1ns / 1ps
`default_nettype none

module scalar_kalman_filter
  import skf_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // measurement word
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [W-1:0]         in_tdata,   // [31:0] measurement
  // result word
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  output logic [2*W-1:0]            out_tdata,  // [31:0] filtered_estimate,
                                                // [63:32] predicted_estimate
  output logic                      out_tuser,  // [0] divide_fault
  // register writes
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [W-1:0]         cfg_data
);

  // --- configuration registers
  logic signed [W-1:0]    f_r, h_r, init_est_r;
  logic [NARROW_W-1:0]    r_r, init_cov_r;

  // --- filter state and working registers
  logic signed [W-1:0]    est_r, cov_r;       // carried between measurements
  logic signed [W-1:0]    z_r, x_r, p_r, t_r, y_r, s_r, k_r;
  logic                   fault_r;

  // --- sequencer
  state_t                 state_r, state_nxt;
  step_t                  op_r;

  // --- gain divider (restoring, one quotient bit a cycle)
  logic [DIV_W-1:0]       q_r;
  logic [W-1:0]           rem_r;
  logic [W-1:0]           dv_r;
  logic                   neg_r;
  logic [DIV_CNT_W-1:0]   div_cnt_r;
  logic [W:0]             trial;
  logic                   ge;
  logic signed [W-1:0]    k_sat;
  logic [W-1:0]           num_mag, s_mag;

  // --- output register
  logic                   out_valid_r;
  logic signed [W-1:0]    filt_out_r, pred_out_r;
  logic                   fault_out_r;

  // --- multiplier hookup
  mul_req_t               mreq;
  mul_rsp_t               mrsp;

  logic in_fire, cfg_fire, out_free;
  assign in_fire  = in_tvalid & in_tready;
  assign cfg_ready = 1'b1;
  assign cfg_fire = cfg_valid & cfg_ready;
  assign out_free = !out_valid_r || out_tready;

  skf_serial_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mreq),
    .rsp   (mrsp)
  );

  // saturate an exact 33-bit sum to W bits
  function automatic logic signed [W-1:0] sat33(input logic signed [W:0] v);
    if (v[W] != v[W-1]) begin
      sat33 = v[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    end else begin
      sat33 = v[W-1:0];
    end
  endfunction

  // --- next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_fire) state_nxt = ST_LAUNCH;
      ST_LAUNCH: state_nxt = ST_MUL;
      ST_MUL: begin
        if (mrsp.done) begin
          priority if (op_r == OP_TP) begin
            state_nxt = ST_DONE;
          end else if (op_r == OP_PH && s_r != '0) begin
            state_nxt = ST_DIV;
          end else begin
            state_nxt = ST_LAUNCH;
          end
        end
      end
      ST_DIV:    if (div_cnt_r == '0) state_nxt = ST_DIVFIN;
      ST_DIVFIN: state_nxt = ST_LAUNCH;
      ST_DONE:   if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // --- sequencer outputs: handshake and multiplier operands
  always_comb begin
    in_tready  = (state_r == ST_IDLE);
    mreq.start = (state_r == ST_LAUNCH);
    unique case (op_r)
      OP_FX:   begin mreq.a = f_r; mreq.b = est_r; end
      OP_FP:   begin mreq.a = f_r; mreq.b = cov_r; end
      OP_TF:   begin mreq.a = t_r; mreq.b = f_r;   end
      OP_HX:   begin mreq.a = h_r; mreq.b = x_r;   end
      OP_HP:   begin mreq.a = h_r; mreq.b = p_r;   end
      OP_TH:   begin mreq.a = t_r; mreq.b = h_r;   end
      OP_PH:   begin mreq.a = p_r; mreq.b = h_r;   end
      OP_KY:   begin mreq.a = k_r; mreq.b = y_r;   end
      OP_KH:   begin mreq.a = k_r; mreq.b = h_r;   end
      OP_TP:   begin mreq.a = t_r; mreq.b = p_r;   end
      default: begin mreq.a = '0;  mreq.b = '0;    end
    endcase
  end

  // --- divider step and final gain saturation
  assign trial   = {rem_r, q_r[DIV_W-1]} - {1'b0, dv_r};
  assign ge      = !trial[W];
  assign num_mag = mrsp.res[W-1] ? (~mrsp.res + 1'b1) : mrsp.res;
  assign s_mag   = s_r[W-1] ? (~s_r + 1'b1) : s_r;

  always_comb begin
    if (neg_r) begin
      if (q_r > DIV_W'({1'b1, {(W-1){1'b0}}})) begin
        k_sat = {1'b1, {(W-1){1'b0}}};
      end else begin
        k_sat = ~q_r[W-1:0] + 1'b1;
      end
    end else if (q_r > DIV_W'({1'b0, {(W-1){1'b1}}})) begin
      k_sat = {1'b0, {(W-1){1'b1}}};
    end else begin
      k_sat = q_r[W-1:0];
    end
  end

  // --- control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      op_r        <= OP_FX;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      // a new result may load in the same cycle the old one is taken
      if (state_r == ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      priority if (state_r == ST_IDLE && in_fire) begin
        op_r <= OP_FX;
      end else if (state_r == ST_MUL && mrsp.done && op_r != OP_TP) begin
        op_r <= step_t'(op_r + 1'b1);
      end else begin
        op_r <= op_r;
      end
    end
  end

  // --- datapath, configuration and carried state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_r        <= ONE_FX;
      h_r        <= ONE_FX;
      r_r        <= NARROW_W'(ONE_FX);
      init_est_r <= '0;
      init_cov_r <= NARROW_W'(ONE_FX);
      est_r      <= '0;
      cov_r      <= ONE_FX;
    end else begin
      // work of the current measurement
      if (state_r == ST_IDLE && in_fire) begin
        z_r     <= in_tdata;
        fault_r <= 1'b0;
      end
      if (state_r == ST_MUL && mrsp.done) begin
        unique case (op_r)
          OP_FX:   x_r <= mrsp.res;
          OP_FP:   t_r <= mrsp.res;
          OP_TF:   p_r <= mrsp.res;
          OP_HX:   y_r <= sat33({z_r[W-1], z_r} - {mrsp.res[W-1], mrsp.res});
          OP_HP:   t_r <= mrsp.res;
          OP_TH:   s_r <= sat33({mrsp.res[W-1], mrsp.res} + {2'b00, r_r});
          OP_PH: begin
            if (s_r == '0) begin
              // zero innovation variance: no correction this time
              k_r     <= '0;
              fault_r <= 1'b1;
            end else begin
              q_r       <= {num_mag, {FRAC_BITS{1'b0}}};
              rem_r     <= '0;
              dv_r      <= s_mag;
              neg_r     <= mrsp.res[W-1] ^ s_r[W-1];
              div_cnt_r <= DIV_CNT_W'(DIV_W - 1);
            end
          end
          OP_KY:   est_r <= sat33({x_r[W-1], x_r} + {mrsp.res[W-1], mrsp.res});
          OP_KH:   t_r   <= mrsp.res;
          OP_TP:   cov_r <= sat33({p_r[W-1], p_r} - {mrsp.res[W-1], mrsp.res});
          default: t_r   <= t_r;
        endcase
      end
      if (state_r == ST_DIV) begin
        rem_r     <= ge ? trial[W-1:0] : {rem_r[W-2:0], q_r[DIV_W-1]};
        q_r       <= {q_r[DIV_W-2:0], ge};
        div_cnt_r <= div_cnt_r - 1'b1;
      end
      if (state_r == ST_DIVFIN) begin
        k_r <= k_sat;
      end
      if (state_r == ST_DONE && out_free) begin
        filt_out_r  <= est_r;
        pred_out_r  <= x_r;
        fault_out_r <= fault_r;
      end

      // register writes; initial registers reload the state
      if (cfg_fire) begin
        unique case (cfg_index)
          REG_TRANSITION: f_r <= cfg_data;
          REG_OBSERVE:    h_r <= cfg_data;
          REG_NOISE:      r_r <= cfg_data[NARROW_W-1:0];
          REG_INIT_EST: begin
            init_est_r <= cfg_data;
            est_r      <= cfg_data;
            cov_r      <= {1'b0, init_cov_r};
          end
          REG_INIT_COV: begin
            init_cov_r <= cfg_data[NARROW_W-1:0];
            est_r      <= init_est_r;
            cov_r      <= {1'b0, cfg_data[NARROW_W-1:0]};
          end
          default: f_r <= f_r;
        endcase
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {pred_out_r, filt_out_r};
  assign out_tuser  = fault_out_r;

  // --- checks
  a_start_idle_mul: assert property (@(posedge clk) disable iff (!rst_n)
    mreq.start |-> !mrsp.busy)
    else $error("multiplier started while busy");

  a_done_in_mul: assert property (@(posedge clk) disable iff (!rst_n)
    mrsp.done |-> (state_r == ST_MUL))
    else $error("product finished outside the multiply state");

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (dv_r != '0))
    else $error("division by zero innovation variance");

  a_fault_gain: assert property (@(posedge clk) disable iff (!rst_n)
    (fault_r && (state_r == ST_LAUNCH || state_r == ST_MUL)) |-> (k_r == '0))
    else $error("fault raised with nonzero gain");

  a_result_when_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result loaded outside the done state");

endmodule

`default_nettype wire
